[hdl/ebp_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ebp_pkg
// Shared types and constants for the exp-golomb bit packer.
// ----------------------------------------------------------------------------
package ebp_pkg;

  localparam int unsigned BYTE_W = 8;
  localparam int unsigned BUF_W  = 72;  // 7 pending bits + 63 code bits, byte rounded
  localparam int unsigned TOT_W  = 7;   // bit count of one packing step, 0..70
  localparam int unsigned NB_W   = 4;   // bytes in one burst, 0..8

  typedef enum logic [1:0] {
    OP_RAW   = 2'd0,
    OP_EXPG  = 2'd1,
    OP_FLUSH = 2'd2
  } ebp_op_e;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [31:0] value;
    logic [5:0]  width;
  } ebp_in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last;
    logic       error;
  } ebp_out_t;

  typedef struct packed {
    logic [BUF_W-1:0] bits;
    logic [NB_W-1:0]  nbytes;
    logic             err;
  } ebp_burst_t;

endpackage

[hdl/ebp_pack.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ebp_pack
// Packing step: merges one command with the pending bits and produces the
// left-aligned burst of completed bytes; holds the pending bit state.
// ----------------------------------------------------------------------------
module ebp_pack #(
  parameter int unsigned VALUE_BITS = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  ebp_pkg::ebp_in_t   item_i,
  input  logic               load_i,
  output ebp_pkg::ebp_burst_t burst_o
);
  import ebp_pkg::*;

  localparam logic [31:0] VMASK = 32'((64'd1 << VALUE_BITS) - 64'd1);
  localparam logic [5:0]  VB6   = 6'(VALUE_BITS);

  logic [6:0]       pend_q, pend_d;
  logic [2:0]       cnt_q, cnt_d;
  logic [31:0]      vm;
  logic [5:0]       len;
  logic [5:0]       wsat;
  logic [6:0]       nbits;
  logic [63:0]      v64;
  logic             err;
  logic [TOT_W-1:0] total;
  logic [BUF_W-1:0] acc;
  logic [BUF_W-1:0] aligned;
  logic [6:0]       lsh;

  assign vm   = item_i.value & VMASK;
  assign wsat = (item_i.width > VB6) ? VB6 : item_i.width;

  // bit length of the coded value
  always_comb begin
    len = '0;
    for (int i = 0; i < 32; i++) begin
      if (vm[i]) begin
        len = 6'(i + 1);
      end
    end
  end

  always_comb begin
    nbits = '0;
    v64   = '0;
    err   = 1'b0;
    unique case (item_i.opcode)
      OP_RAW: begin
        nbits = {1'b0, wsat};
        v64   = {32'b0, vm} & ((64'd1 << wsat) - 64'd1);
      end
      OP_EXPG: begin
        if (vm == '0) begin
          err = 1'b1;
        end else begin
          nbits = 7'({len, 1'b0} - 7'd1);
          v64   = {32'b0, vm};
        end
      end
      OP_FLUSH: begin
        nbits = (cnt_q == '0) ? 7'd0 : 7'(4'd8 - {1'b0, cnt_q});
      end
      default: begin
        nbits = '0;
      end
    endcase
  end

  assign total   = 7'({4'b0, cnt_q} + nbits);
  assign acc     = ({65'b0, pend_q} << nbits) | {8'b0, v64};
  assign lsh     = 7'(BUF_W) - total;
  assign aligned = acc << lsh;

  always_comb begin
    if (err) begin
      burst_o.bits   = '0;
      burst_o.nbytes = NB_W'(1);
      burst_o.err    = 1'b1;
    end else begin
      burst_o.bits   = aligned;
      burst_o.nbytes = total[TOT_W-1:3];
      burst_o.err    = 1'b0;
    end
  end

  always_comb begin
    pend_d = pend_q;
    cnt_d  = cnt_q;
    if (load_i && !err) begin
      cnt_d  = total[2:0];
      pend_d = acc[6:0] & 7'((8'd1 << total[2:0]) - 8'd1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
      cnt_q  <= '0;
    end else begin
      pend_q <= pend_d;
      cnt_q  <= cnt_d;
    end
  end

endmodule

[hdl/ebp_ser.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ebp_ser
// Result register: holds one burst and hands it out one word at a time.
// ----------------------------------------------------------------------------
module ebp_ser (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  ebp_pkg::ebp_burst_t burst_i,
  input  logic                load_i,
  output logic                free_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output ebp_pkg::ebp_out_t   out_data_o
);
  import ebp_pkg::*;

  logic [BUF_W-1:0] buf_q, buf_d;
  logic [NB_W-1:0]  rem_q, rem_d;
  logic             err_q, err_d;
  logic             take;

  assign out_valid_o         = (rem_q != '0);
  assign take                = out_valid_o && out_ready_i;
  assign free_o              = (rem_q == '0) || (take && rem_q == NB_W'(1));
  assign out_data_o.out_byte = buf_q[BUF_W-1 -: BYTE_W];
  assign out_data_o.last     = (rem_q == NB_W'(1));
  assign out_data_o.error    = err_q;

  always_comb begin
    buf_d = buf_q;
    rem_d = rem_q;
    err_d = err_q;
    if (load_i) begin
      buf_d = burst_i.bits;
      rem_d = burst_i.nbytes;
      err_d = burst_i.err;
    end else if (take) begin
      buf_d = buf_q << BYTE_W;
      rem_d = rem_q - NB_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q <= '0;
      err_q <= 1'b0;
    end else begin
      rem_q <= rem_d;
      err_q <= err_d;
    end
  end

  always_ff @(posedge clk_i) begin
    buf_q <= buf_d;
  end

endmodule

[hdl/exp_golomb_bit_packer_unit.sv]
`timescale 1ns / 1ps
// a command waits in the input register until the result register is free, then
//   is loaded into it; its first word is offered from the result register
// throughput: one command per cycle while each makes at most one word and the
//   receiver is ready; k words (k up to 8) hold the result register until taken
// reset: asynchronous, active low; clears pending bits, count and valid flags
// ----------------------------------------------------------------------------
// exp_golomb_bit_packer_unit
// MSB-first bit packer with order-0 exp-golomb coding and flush.
// ----------------------------------------------------------------------------
module exp_golomb_bit_packer_unit #(
  parameter int unsigned VALUE_BITS = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  ebp_pkg::ebp_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output ebp_pkg::ebp_out_t out_data_o
);
  import ebp_pkg::*;

  ebp_in_t    in_q;
  logic       in_vld_q;
  logic       free;
  logic       advance;
  ebp_burst_t burst;

  assign advance    = in_vld_q && free;
  assign in_ready_o = !in_vld_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_valid_i && in_ready_o) begin
      in_vld_q <= 1'b1;
    end else if (advance) begin
      in_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_q <= in_data_i;
    end
  end

  ebp_pack #(
    .VALUE_BITS(VALUE_BITS)
  ) u_pack (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .item_i (in_q),
    .load_i (advance),
    .burst_o(burst)
  );

  ebp_ser u_ser (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .burst_i    (burst),
    .load_i     (advance),
    .free_o     (free),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

endmodule

[hdl/ebp_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ebp_checker
// Port-level checks for the exp-golomb bit packer, bound to the top level.
// ----------------------------------------------------------------------------
module ebp_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_ready_i,
  input logic              out_valid_i,
  input logic              out_ready_i,
  input ebp_pkg::ebp_out_t out_data_i
);
  import ebp_pkg::*;

  // stalled word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_data_i))
    else $error("output word changed while stalled");

  // error word is a lone zero word
  a_err_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_data_i.error |-> out_data_i.last && out_data_i.out_byte == 8'd0)
    else $error("error word not a zero last word");

  // a burst runs without gaps until its last word
  a_burst_cont: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_ready_i && !out_data_i.last |=> out_valid_i)
    else $error("gap inside a burst");

  // idle result side never blocks input
  a_ready_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_i |-> in_ready_i)
    else $error("input stalled with empty result register");

endmodule

bind exp_golomb_bit_packer_unit ebp_checker u_ebp_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_ready_i (in_ready_o),
  .out_valid_i(out_valid_o),
  .out_ready_i(out_ready_i),
  .out_data_i (out_data_o)
);

[bench/tb_exp_golomb_bit_packer_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_exp_golomb_bit_packer_unit
// Self-checking bench for the exp-golomb bit packer. A queue-fed driver sends
// raw, exp-golomb, flush and unused commands. A bit-serial model of the packer
// predicts every output word, and a monitor compares each word field by field.
// The run goes through phases of sender idling and receiver stalling, plus one
// long receiver hold-off that backs the block up into its input.
// ----------------------------------------------------------------------------
module tb_exp_golomb_bit_packer_unit;
  import ebp_pkg::*;

  localparam int unsigned VALUE_BITS = 32;
  localparam logic [1:0]  OP_UNUSED  = 2'd3;
  localparam int          HOLD_LEN   = 300;

  logic     clk_i       = 1'b0;
  logic     rst_ni      = 1'b0;
  logic     in_valid_i  = 1'b0;
  logic     in_ready_o;
  ebp_in_t  in_data_i   = '0;
  logic     out_valid_o;
  logic     out_ready_i = 1'b0;
  ebp_out_t out_data_o;

  ebp_in_t  cmd_q[$];
  ebp_out_t word_q[$];
  logic [7:0] byte_q[$];

  logic [6:0]  pend_bits = '0;
  int unsigned pend_cnt  = 0;

  int idle_pct  = 0;
  int stall_pct = 0;
  logic hold_tgl  = 1'b0;
  logic hold_seen = 1'b0;
  int   hold_left = 0;

  int err_cnt   = 0;
  int n_cmds    = 0;
  int n_words   = 0;
  int n_zero_eg = 0;

  exp_golomb_bit_packer_unit #(
    .VALUE_BITS(VALUE_BITS)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  always #4 clk_i = ~clk_i;

  // bit-serial packer state, msb of each code first
  function automatic void shift_bit(logic b);
    logic [7:0] nxt;
    nxt = {pend_bits, b};
    if (pend_cnt == 7) begin
      byte_q.push_back(nxt);
      pend_bits = '0;
      pend_cnt  = 0;
    end else begin
      pend_bits = nxt[6:0];
      pend_cnt++;
    end
  endfunction

  function automatic void pack_cmd(ebp_in_t cmd);
    int       nbits;
    int       len;
    ebp_out_t w;
    byte_q.delete();
    case (cmd.opcode)
      OP_RAW: begin
        nbits = (cmd.width > VALUE_BITS) ? VALUE_BITS : cmd.width;
        for (int i = nbits - 1; i >= 0; i--) shift_bit(cmd.value[i]);
      end
      OP_EXPG: begin
        if (cmd.value == '0) begin
          w.out_byte = '0;
          w.last     = 1'b1;
          w.error    = 1'b1;
          word_q.push_back(w);
          return;
        end
        len = 0;
        for (int i = 0; i < 32; i++) if (cmd.value[i]) len = i + 1;
        for (int i = 0; i < len - 1; i++) shift_bit(1'b0);
        for (int i = len - 1; i >= 0; i--) shift_bit(cmd.value[i]);
      end
      OP_FLUSH: begin
        if (pend_cnt > 0) begin
          byte_q.push_back(8'({1'b0, pend_bits} << (8 - pend_cnt)));
          pend_bits = '0;
          pend_cnt  = 0;
        end
      end
      default: ;
    endcase
    for (int k = 0; k < byte_q.size(); k++) begin
      w.out_byte = byte_q[k];
      w.last     = (k == byte_q.size() - 1);
      w.error    = 1'b0;
      word_q.push_back(w);
    end
  endfunction

  // driver
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        pack_cmd(in_data_i);
        n_cmds++;
      end
      if (!in_valid_i || in_ready_o) begin
        if (cmd_q.size() > 0 && $urandom_range(0, 99) >= idle_pct) begin
          in_valid_i <= 1'b1;
          in_data_i  <= cmd_q.pop_front();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // receiver ready, with a long hold-off on request
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else if (hold_tgl != hold_seen) begin
      hold_seen   <= hold_tgl;
      hold_left   <= HOLD_LEN;
      out_ready_i <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left   <= hold_left - 1;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  // monitor
  always @(posedge clk_i) begin
    ebp_out_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      n_words++;
      if (out_data_o.error) n_zero_eg++;
      if (word_q.size() == 0) begin
        $error("unexpected word %h", out_data_o);
        err_cnt++;
      end else begin
        want = word_q.pop_front();
        if (out_data_o.out_byte !== want.out_byte) begin
          $error("out_byte: expected %h, got %h", want.out_byte, out_data_o.out_byte);
          err_cnt++;
        end
        if (out_data_o.last !== want.last) begin
          $error("last: expected %b, got %b", want.last, out_data_o.last);
          err_cnt++;
        end
        if (out_data_o.error !== want.error) begin
          $error("error: expected %b, got %b", want.error, out_data_o.error);
          err_cnt++;
        end
      end
    end
  end

  task automatic add_cmd(logic [1:0] op, logic [31:0] v, logic [5:0] w);
    ebp_in_t c;
    c.opcode = op;
    c.value  = v;
    c.width  = w;
    cmd_q.push_back(c);
  endtask

  function automatic ebp_in_t rand_cmd();
    ebp_in_t c;
    int      r;
    int      len;
    r       = $urandom_range(0, 99);
    c.value = $urandom;
    c.width = 6'($urandom_range(0, 63));
    if (r < 40) begin
      c.opcode = OP_RAW;
      if ($urandom_range(0, 9) < 7) c.width = 6'($urandom_range(1, 16));
    end else if (r < 73) begin
      c.opcode = OP_EXPG;
      len      = $urandom_range(1, 32);
      c.value  = ($urandom >> (32 - len)) | (32'h1 << (len - 1));
    end else if (r < 77) begin
      c.opcode = OP_EXPG;
      c.value  = '0;
    end else if (r < 95) begin
      c.opcode = OP_FLUSH;
    end else begin
      c.opcode = OP_UNUSED;
    end
    return c;
  endfunction

  task automatic settle();
    int waited;
    waited = 0;
    while ((cmd_q.size() > 0 || in_valid_i || word_q.size() > 0) && waited < 50000) begin
      @(negedge clk_i);
      waited++;
    end
    repeat (16) @(negedge clk_i);
    if (word_q.size() != 0 || cmd_q.size() != 0) begin
      $error("%0d words still expected, %0d commands unsent", word_q.size(), cmd_q.size());
      err_cnt++;
      word_q.delete();
      cmd_q.delete();
    end
  endtask

  task automatic run_phase(int idle, int stall, int n);
    @(negedge clk_i);
    idle_pct  = idle;
    stall_pct = stall;
    repeat (n) cmd_q.push_back(rand_cmd());
    settle();
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    add_cmd(OP_RAW, 32'hFFFF_FFFF, 6'd0);
    add_cmd(OP_FLUSH, 32'h0, 6'd0);
    add_cmd(OP_RAW, 32'h0000_0001, 6'd1);
    add_cmd(OP_RAW, 32'hFFFF_FFFF, 6'd32);
    add_cmd(OP_FLUSH, 32'hFFFF_FFFF, 6'd63);
    add_cmd(OP_RAW, 32'hA5C3_0F96, 6'd63);
    add_cmd(OP_RAW, 32'h5A3C_F069, 6'd33);
    add_cmd(OP_RAW, 32'h0000_0005, 6'd3);
    add_cmd(OP_EXPG, 32'h0, 6'd0);
    add_cmd(OP_FLUSH, 32'h0, 6'd0);
    add_cmd(OP_EXPG, 32'h1, 6'd0);
    add_cmd(OP_EXPG, 32'h2, 6'd0);
    add_cmd(OP_EXPG, 32'h3, 6'd0);
    add_cmd(OP_FLUSH, 32'h0, 6'd0);
    add_cmd(OP_RAW, 32'h0000_007F, 6'd7);
    add_cmd(OP_EXPG, 32'hFFFF_FFFF, 6'd63);
    add_cmd(OP_EXPG, 32'h8000_0000, 6'd0);
    add_cmd(OP_UNUSED, 32'hFFFF_FFFF, 6'd63);
    add_cmd(OP_RAW, 32'h0000_00FF, 6'd8);
    add_cmd(OP_EXPG, 32'h0, 6'd17);
    add_cmd(OP_FLUSH, 32'h0, 6'd0);
    settle();

    run_phase(0, 0, 85);
    run_phase(71, 0, 85);
    run_phase(0, 71, 85);
    run_phase(36, 36, 85);

    // receiver holds off while commands keep coming
    @(negedge clk_i);
    idle_pct  = 0;
    stall_pct = 0;
    repeat (30) cmd_q.push_back(rand_cmd());
    hold_tgl = ~hold_tgl;
    settle();

    $display("%0d commands sent, %0d words checked, %0d zero-value errors seen",
             n_cmds, n_words, n_zero_eg);
    $display("phases: no idling, sender idle, receiver stall, both, long hold-off");
    if (err_cnt == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("timeout");
    $display("Test completed with failures");
    $finish;
  end

endmodule
